@@ design/gha_pkg.sv @@
// Shared types and constants for the generational handle allocator.
`default_nettype none
package gha_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int IDX_W     = 10;
	localparam int GEN_W     = 16;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_CHECK = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_e_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_FRESH = 2'd1,
		RES_POP   = 2'd2
	} res_sel_t;

	typedef struct packed {
		kind_e_t           kind;
		logic [IDX_W-1:0]  handle_index;
		logic [GEN_W-1:0]  handle_generation;
	} req_t;

	typedef struct packed {
		status_e_t         status;
		logic [IDX_W-1:0]  slot_out;
		logic [GEN_W-1:0]  generation_out;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       accept;
		logic       rd_pop;
		logic       do_fresh;
		logic       do_free;
		logic       do_pop;
		logic       do_clear;
		logic       emit;
		status_e_t  status;
		res_sel_t   res_sel;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		kind_e_t  kind;
		logic     has_free;
		logic     fresh_avail;
		logic     handle_ok;
		logic     stack_full;
	} sts_t;

endpackage
`default_nettype wire

@@ design/gha_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ design/gha_ctrl.sv @@
// Request sequencer for the generational handle allocator.
`default_nettype none
module gha_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire gha_pkg::sts_t sts,
	output gha_pkg::cmd_t      cmd
);
	import gha_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_POP  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_IDLE;
				case (sts.kind)
					KIND_ALLOC: begin
						if (sts.has_free) begin
							// second read: generation of the popped slot
							cmd.rd_pop = 1'b1;
							state_d    = S_POP;
						end else if (sts.fresh_avail) begin
							cmd.do_fresh = 1'b1;
							cmd.emit     = 1'b1;
							cmd.status   = ST_OK;
							cmd.res_sel  = RES_FRESH;
						end else begin
							cmd.emit   = 1'b1;
							cmd.status = ST_FULL;
						end
					end
					KIND_FREE: begin
						cmd.emit = 1'b1;
						if (sts.handle_ok && !sts.stack_full) begin
							cmd.do_free = 1'b1;
							cmd.status  = ST_OK;
						end else begin
							cmd.status = ST_INVALID;
						end
					end
					KIND_CHECK: begin
						cmd.emit   = 1'b1;
						cmd.status = sts.handle_ok ? ST_OK : ST_INVALID;
					end
					KIND_CLEAR: begin
						cmd.do_clear = 1'b1;
						cmd.emit     = 1'b1;
						cmd.status   = ST_OK;
					end
					default: begin
						cmd.emit   = 1'b1;
						cmd.status = ST_INVALID;
					end
				endcase
			end
			S_POP: begin
				cmd.do_pop  = 1'b1;
				cmd.emit    = 1'b1;
				cmd.status  = ST_OK;
				cmd.res_sel = RES_POP;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/gha_dp.sv @@
// Datapath: counters, generation table, free stack and result register.
`default_nettype none
module gha_dp #(
	parameter int SLOTS = gha_pkg::SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gha_pkg::req_t req,
	input  wire gha_pkg::cmd_t cmd,
	output gha_pkg::sts_t      sts,
	output logic               done,
	output gha_pkg::rsp_t      rsp
);
	import gha_pkg::*;

	localparam int AW   = $clog2(SLOTS);
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
	localparam int SXW  = (AW > IDX_W) ? AW : IDX_W;

	req_t            req_q;
	logic [CW-1:0]   free_count_q;
	logic [CW-1:0]   fresh_q;
	logic [AW-1:0]   pop_slot_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic [CMPW-1:0] idx_in_ext, idx_q_ext, fresh_ext;
	logic [AW-1:0]   gen_raddr, gen_waddr, stk_raddr, stk_waddr, idx_q_addr;
	logic [GEN_W-1:0] gen_rdata, gen_wdata;
	logic [AW-1:0]   stk_rdata;
	logic            gen_we;
	logic [SXW-1:0]  slot_ext;

	assign idx_in_ext = CMPW'(req.handle_index);
	assign idx_q_ext  = CMPW'(req_q.handle_index);
	assign fresh_ext  = CMPW'(fresh_q);
	assign idx_q_addr = idx_q_ext[AW-1:0];

	// generation table: read the handle's slot at accept, the popped slot after
	assign gen_raddr = cmd.rd_pop ? stk_rdata : idx_in_ext[AW-1:0];
	assign gen_we    = cmd.do_fresh | cmd.do_free;
	assign gen_waddr = cmd.do_fresh ? fresh_q[AW-1:0] : idx_q_addr;
	assign gen_wdata = cmd.do_fresh ? '0 : gen_rdata + GEN_W'(1);

	// free stack: top entry is read at accept, push goes above it
	assign stk_raddr = AW'(free_count_q - CW'(1));
	assign stk_waddr = free_count_q[AW-1:0];

	gha_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	gha_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_stk_ram (
		.clk   (clk),
		.we    (cmd.do_free),
		.waddr (stk_waddr),
		.wdata (idx_q_addr),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign sts.kind        = req_q.kind;
	assign sts.has_free    = (free_count_q != '0);
	assign sts.fresh_avail = (fresh_q < CW'(SLOTS));
	assign sts.stack_full  = (free_count_q >= CW'(SLOTS));
	assign sts.handle_ok   = (idx_q_ext < fresh_ext) &&
	                         (gen_rdata == req_q.handle_generation);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (cmd.rd_pop) begin
			pop_slot_q <= stk_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= '0;
			fresh_q      <= '0;
		end else begin
			if (cmd.do_clear) begin
				free_count_q <= '0;
				fresh_q      <= '0;
			end else begin
				if (cmd.do_fresh) begin
					fresh_q <= fresh_q + CW'(1);
				end
				if (cmd.do_free) begin
					free_count_q <= free_count_q + CW'(1);
				end else if (cmd.do_pop) begin
					free_count_q <= free_count_q - CW'(1);
				end
			end
		end
	end

	always_comb begin
		case (cmd.res_sel)
			RES_FRESH: slot_ext = SXW'(fresh_q[AW-1:0]);
			RES_POP:   slot_ext = SXW'(pop_slot_q);
			default:   slot_ext = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status         <= cmd.status;
			rsp_q.slot_out       <= slot_ext[IDX_W-1:0];
			rsp_q.generation_out <= (cmd.res_sel == RES_POP) ? gen_rdata : '0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

@@ design/generational_handle_allocator_top.sv @@
// Top level of the generational handle allocator.
//
//  Channel   Signals              Direction  Transfer
//  request   start, busy, req     in         rising edge with start high, busy low
//  result    done, rsp            out        the one cycle done is high
//
// Check, free, clear and a fresh allocate pass the look-up state from transfer to
// result (one synchronous table read, then decide and write back). An allocate that
// reuses a freed slot adds the pop state: the free stack read must land before the
// generation table can be read at that slot.
// Reset clears the counters, the sequencer state and done; the generation table and
// free stack need no clearing pass since no entry is read before it is written.
// busy drops in the cycle done is shown, so a new request transfers at that edge.
// The receiver cannot stall: every result is gone after its single cycle.
`default_nettype none
module generational_handle_allocator_top #(
	parameter int SLOTS = gha_pkg::SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire gha_pkg::req_t req,
	output logic               done,
	output gha_pkg::rsp_t      rsp
);
	import gha_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence each request: accept, look up, optional pop read, emit
	gha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// hold the tables, counters and the result register
	gha_dp #(.SLOTS(SLOTS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

	// a transfer always occupies the sequencer on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request transfer did not occupy the sequencer");

	// results never come in back-to-back cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	// a result follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy))
		else $error("result without a request in flight");

	// only a reused slot carries a nonzero generation
	a_gen_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.res_sel != RES_POP) |=> (rsp.generation_out == '0))
		else $error("nonzero generation on a non-reuse result");

endmodule
`default_nettype wire
